>>> hdl/mcg_pkg.sv
// Shared types and codes for the month calendar grid block.
// Used by the controller, the datapath and the top level; no dependencies.
package mcg_pkg;

    // Datapath operation codes: OP_NONE, then one per setup step
    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL_Y,
        OP_LEAP,
        OP_MUL_YY,
        OP_SUM,
        OP_MUL_SUM,
        OP_FIRST
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic last;
    } t_stat;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DOW_W   = 3;
    localparam int ROW_W   = 3;

endpackage

>>> hdl/mcg_if.sv
// Channel interfaces for the month calendar grid block: request and day words.
// Depends on mcg_pkg for field widths.
interface mcg_req_if;
    import mcg_pkg::*;
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;

    modport source (output valid, year, month, input ready);
    modport sink   (input valid, year, month, output ready);
endinterface

interface mcg_day_if;
    import mcg_pkg::*;
    logic             valid;
    logic             ready;
    logic [DAY_W-1:0] day_number;
    logic [DOW_W-1:0] day_of_week;
    logic [ROW_W-1:0] grid_row;
    logic             last_day;
    logic             bad_date;

    modport source (output valid, day_number, day_of_week, grid_row, last_day, bad_date,
                    input ready);
    modport sink   (input valid, day_number, day_of_week, grid_row, last_day, bad_date,
                    output ready);
endinterface

>>> hdl/mcg_ctrl.sv
// Sequencer for the month calendar grid: steps the datapath through setup,
// then emits one day word per handshake. Depends on mcg_pkg.
module mcg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mcg_pkg::t_cmd  o_cmd,
    input  mcg_pkg::t_stat i_stat
);
    import mcg_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MY    = 3'd1;
    localparam logic [2:0] S_LEAP  = 3'd2;
    localparam logic [2:0] S_MYY   = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_MSUM  = 3'd5;
    localparam logic [2:0] S_FIRST = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.op      = OP_NONE;
        o_cmd.advance = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MY;
                end
            end
            S_MY: begin
                o_cmd.op = OP_MUL_Y;
                // bad request: payload is already zero, go straight out
                n_state  = i_stat.bad ? S_EMIT : S_LEAP;
            end
            S_LEAP: begin
                o_cmd.op = OP_LEAP;
                n_state  = S_MYY;
            end
            S_MYY: begin
                o_cmd.op = OP_MUL_YY;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                n_state  = S_MSUM;
            end
            S_MSUM: begin
                o_cmd.op = OP_MUL_SUM;
                n_state  = S_FIRST;
            end
            S_FIRST: begin
                o_cmd.op = OP_FIRST;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if (i_stat.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

>>> hdl/mcg_dp.sv
// Datapath for the month calendar grid: shared constant multiplier for the
// divisions by 100 and 7, weekday sum, month length and day counters. Depends on mcg_pkg.
module mcg_dp (
    input  logic                        i_clk,
    input  mcg_pkg::t_cmd               i_cmd,
    output mcg_pkg::t_stat              o_stat,
    input  logic [mcg_pkg::YEAR_W-1:0]  i_year,
    input  logic [mcg_pkg::MONTH_W-1:0] i_month,
    output logic [mcg_pkg::DAY_W-1:0]   o_day_number,
    output logic [mcg_pkg::DOW_W-1:0]   o_day_of_week,
    output logic [mcg_pkg::ROW_W-1:0]   o_grid_row,
    output logic                        o_last_day,
    output logic                        o_bad_date
);
    import mcg_pkg::*;

    // floor(x/100) = (x*5243)>>19 for x < 10000; floor(x/7) = (x*2341)>>14 for x < 1024
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam logic [11:0] RECIP_7   = 12'd2341;
    localparam int          PROD_W    = 27;

    function automatic logic [5:0] zeller_term(input logic [MONTH_W-1:0] mm);
        logic [5:0] t;
        unique case (mm)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    function automatic logic [DAY_W-1:0] base_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] l;
        unique case (m)
            4'd2:                      l = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   l = 5'd30;
            default:                   l = 5'd31;
        endcase
        return l;
    endfunction

    logic [YEAR_W-1:0]  r_year;
    logic [MONTH_W-1:0] r_month;
    logic               r_bad;
    logic [PROD_W-1:0]  r_prod;
    logic               r_leap;
    logic [9:0]         r_sum;
    logic [DAY_W-1:0]   r_len;
    logic [DAY_W-1:0]   r_day;
    logic [DOW_W-1:0]   r_dow;
    logic [ROW_W-1:0]   r_row;

    logic               early;
    logic [YEAR_W-1:0]  prev_year;
    logic [MONTH_W-1:0] zmonth;
    logic [YEAR_W-1:0]  div_src;
    logic [6:0]         cent;
    logic [YEAR_W-1:0]  rem_full;
    logic [6:0]         yrem;
    logic [9:0]         sum;
    logic [6:0]         q7;
    logic [9:0]         rem7;
    logic [DOW_W-1:0]   first;
    logic               in_bad;

    // January and February count as months 13 and 14 of the year before
    assign early     = (r_month <= 4'd2);
    assign prev_year = early ? (r_year - YEAR_W'(1)) : r_year;
    assign zmonth    = early ? (r_month + 4'd12) : r_month;

    assign div_src  = (i_cmd.op == OP_LEAP) ? r_year : prev_year;
    assign cent     = r_prod[25:19];
    assign rem_full = div_src - (YEAR_W'(cent) * YEAR_W'(100));
    assign yrem     = rem_full[6:0];

    assign sum = 10'(yrem) + 10'(yrem >> 2) + 10'(cent >> 2) + (10'(cent) * 10'd5)
               + 10'(zeller_term(zmonth));

    assign q7    = r_prod[20:14];
    assign rem7  = r_sum - (10'(q7) * 10'd7);
    assign first = rem7[DOW_W-1:0];

    assign in_bad = (i_month < 4'd1) || (i_month > 4'd12)
                 || (i_year < 14'd1) || (i_year > 14'd9999);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year  <= i_year;
            r_month <= i_month;
            r_bad   <= in_bad;
            r_day   <= '0;
            r_dow   <= '0;
            r_row   <= '0;
        end
        unique case (i_cmd.op)
            OP_MUL_Y:   r_prod <= PROD_W'(r_year) * PROD_W'(RECIP_100);
            OP_LEAP:    r_leap <= (r_year[1:0] == 2'd0) && ((yrem != 7'd0) || (cent[1:0] == 2'd0));
            OP_MUL_YY:  r_prod <= PROD_W'(prev_year) * PROD_W'(RECIP_100);
            OP_SUM:     r_sum  <= sum;
            OP_MUL_SUM: r_prod <= PROD_W'(r_sum) * PROD_W'(RECIP_7);
            OP_FIRST: begin
                r_len <= base_len(r_month) + DAY_W'((r_month == 4'd2) && r_leap);
                r_day <= DAY_W'(1);
                r_dow <= first;
                r_row <= '0;
            end
            default: ;
        endcase
        if (i_cmd.advance) begin
            r_day <= r_day + DAY_W'(1);
            // wrap to Sunday and drop to the next grid row
            if (r_dow == 3'd6) begin
                r_dow <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_dow <= r_dow + DOW_W'(1);
            end
        end
    end

    assign o_stat.bad   = r_bad;
    assign o_stat.last  = r_bad || (r_day == r_len);
    assign o_day_number  = r_day;
    assign o_day_of_week = r_dow;
    assign o_grid_row    = r_row;
    assign o_last_day    = o_stat.last;
    assign o_bad_date    = r_bad;
endmodule

>>> hdl/month_calendar_grid.sv
// Month calendar grid: one (year, month) request in, one word per day out, one if bad.
// Setup: S_MY to S_FIRST precede the first day word; a bad date goes out after S_MY.
// Throughput: no new request is taken until the last day word has gone; the six-step
// setup shares the constant multiplier, then one day word per cycle while ready is high.
// Reset: synchronous active-low reset returns the sequencer to idle; no data is cleared.
module month_calendar_grid (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mcg_req_if.sink   i_req,
    mcg_day_if.source o_day
);
    import mcg_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    mcg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_day.valid),
        .i_out_ready (o_day.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    mcg_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_year        (i_req.year),
        .i_month       (i_req.month),
        .o_day_number  (o_day.day_number),
        .o_day_of_week (o_day.day_of_week),
        .o_grid_row    (o_day.grid_row),
        .o_last_day    (o_day.last_day),
        .o_bad_date    (o_day.bad_date)
    );
endmodule

>>> tb/tb.sv
// Self-checking testbench for month_calendar_grid: random and directed year/month requests.
// Predicts every day word per request; depends on mcg_pkg, mcg_if.sv and the block's RTL.
`timescale 1ns / 100ps

module tb;
    import mcg_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 305;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [DAY_W-1:0] day_number;
        logic [DOW_W-1:0] day_of_week;
        logic [ROW_W-1:0] grid_row;
        logic             last_day;
        logic             bad_date;
    } t_day_word;

    class day_scoreboard;
        t_day_word expected_days[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // Append one expected word at the tail of the queue
        function void enqueue_word(t_day_word w);
            expected_days.insert(expected_days.size(), w);
        endfunction

        // Lay out the month the way the block should and queue one word per day
        function void note_request(logic [YEAR_W-1:0] year, logic [MONTH_W-1:0] month);
            int unsigned y, m, yy, mm, k, j, first, len, pos;
            bit          leap;
            t_day_word   w;
            y = year;
            m = month;
            if (m < 1 || m > 12 || y < 1 || y > 9999) begin
                w          = '0;
                w.last_day = 1'b1;
                w.bad_date = 1'b1;
                enqueue_word(w);
                return;
            end
            // January and February count as months 13 and 14 of the year before
            yy = (m <= 2) ? y - 1 : y;
            mm = (m <= 2) ? m + 12 : m;
            k  = yy % 100;
            j  = yy / 100;
            first = (k + k / 4 + j / 4 + 5 * j + (26 * (mm + 1)) / 10) % 7;
            leap  = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            unique case (m)
                2:          len = leap ? 29 : 28;
                4, 6, 9, 11: len = 30;
                default:    len = 31;
            endcase
            for (int unsigned d = 1; d <= len; d++) begin
                pos           = first + d - 1;
                w.day_number  = d[DAY_W-1:0];
                w.day_of_week = DOW_W'(pos % 7);
                w.grid_row    = ROW_W'(pos / 7);
                w.last_day    = (d == len);
                w.bad_date    = 1'b0;
                enqueue_word(w);
            end
        endfunction

        function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
            if (exp_val != act_val) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_word(t_day_word got);
            t_day_word want;
            if (expected_days.size() == 0) begin
                $display("%0t: extra day word: expected none, actual %0d/%0d/%0d/%0d/%0d",
                         $time, got.day_number, got.day_of_week, got.grid_row,
                         got.last_day, got.bad_date);
                errors++;
                return;
            end
            want = expected_days.pop_front();
            compare_field("day_number",  want.day_number,  got.day_number);
            compare_field("day_of_week", want.day_of_week, got.day_of_week);
            compare_field("grid_row",    want.grid_row,    got.grid_row);
            compare_field("last_day",    want.last_day,    got.last_day);
            compare_field("bad_date",    want.bad_date,    got.bad_date);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    int   cycles;

    day_scoreboard sb;

    mcg_req_if req_if ();
    mcg_day_if day_if ();

    month_calendar_grid i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_day   (day_if.source)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Mostly short gaps, a few long ones; none during quiet stretches
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_request(input logic [YEAR_W-1:0] year, input logic [MONTH_W-1:0] month);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.year  <= year;
        req_if.month <= month;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(year, month);
    endtask

    // Day word sink: check accepted words, then pick the next ready value
    always @(posedge i_clk) begin : day_sink
        t_day_word got;
        static int stall_left = 0;
        int        n;
        if (i_rst_n && day_if.valid && day_if.ready) begin
            got.day_number  = day_if.day_number;
            got.day_of_week = day_if.day_of_week;
            got.grid_row    = day_if.grid_row;
            got.last_day    = day_if.last_day;
            got.bad_date    = day_if.bad_date;
            sb.check_word(got);
        end
        if (stall_left > 0) begin
            day_if.ready <= 1'b0;
            stall_left--;
        end else begin
            n = pick_gap();
            if (n > 0) begin
                day_if.ready <= 1'b0;
                stall_left = n - 1;
            end else begin
                day_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[month_calendar_grid] ERROR");
            $finish;
        end
    end

    initial begin
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        int                 r;
        sb           = new();
        cycles       = 0;
        quiet        = 1'b0;
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.year  = '0;
        req_if.month = '0;
        day_if.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: year and century edges, leap rules, every month, bad dates
        send_request(14'd1, 4'd1);
        send_request(14'd1, 4'd2);
        send_request(14'd1, 4'd12);
        send_request(14'd9999, 4'd12);
        send_request(14'd9999, 4'd2);
        send_request(14'd2000, 4'd2);
        send_request(14'd1900, 4'd2);
        send_request(14'd2024, 4'd2);
        send_request(14'd2023, 4'd2);
        for (int m = 3; m <= 11; m++) send_request(14'd2025, m[MONTH_W-1:0]);
        send_request(14'd0, 4'd1);
        send_request(14'd10000, 4'd6);
        send_request(14'd16383, 4'd15);
        send_request(14'd9999, 4'd0);
        send_request(14'd2020, 4'd13);
        send_request(14'd1, 4'd15);
        send_request(14'd0, 4'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 15) begin
                // Noise: any bit pattern, mostly out of range
                year  = YEAR_W'($urandom_range(0, 16383));
                month = MONTH_W'($urandom_range(0, 15));
            end else if (r < 27) begin
                // Century and leap boundaries in February
                year  = YEAR_W'($urandom_range(1, 99) * 100 + $urandom_range(0, 1) * 4);
                month = 4'd2;
            end else if (r < 32) begin
                // Year before is year zero or near it
                year  = YEAR_W'($urandom_range(1, 3));
                month = MONTH_W'($urandom_range(1, 2));
            end else begin
                year  = YEAR_W'($urandom_range(1, 9999));
                month = MONTH_W'($urandom_range(1, 12));
            end
            send_request(year, month);
        end
        req_if.valid <= 1'b0;

        while (sb.expected_days.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_days.size() == 0) begin
            $display("[month_calendar_grid] OK");
        end else begin
            $display("[month_calendar_grid] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/mcg_pkg.sv
hdl/mcg_if.sv
hdl/mcg_ctrl.sv
hdl/mcg_dp.sv
hdl/month_calendar_grid.sv
tb/tb.sv
